[rtl/crr_pkg.sv]
// Shared constants and types for the chained range remap block.
`timescale 1ns / 1ps
`default_nettype none

package crr_pkg;

  localparam int STAGES   = 7;
  localparam int SEGMENTS = 16;

  localparam int KeyW   = 32;
  localparam int StageW = 3;
  localparam int SlotW  = 4;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XLATE = 1'b1
  } crr_op_e;

  // Pipeline payload. For a load, key holds the source start and off holds
  // dst_start - src_start; for a translate, off holds the selected offset.
  typedef struct packed {
    crr_op_e             op;
    logic [StageW-1:0]   stage;
    logic [SlotW-1:0]    slot;
    logic [KeyW-1:0]     key;
    logic [KeyW-1:0]     off;
    logic [KeyW-1:0]     span;
  } crr_pipe_t;

endpackage

`default_nettype wire

[rtl/crr_in_if.sv]
// Input channel: load and translate transactions.
`timescale 1ns / 1ps
`default_nettype none

interface crr_in_if
  import crr_pkg::*;
();
  logic                valid;
  logic                ready;
  crr_op_e             op;
  logic [StageW-1:0]   stage;
  logic [SlotW-1:0]    slot;
  logic [KeyW-1:0]     src_start;
  logic [KeyW-1:0]     dst_start;
  logic [KeyW-1:0]     span;
  logic [KeyW-1:0]     key;

  modport source (
    output valid, op, stage, slot, src_start, dst_start, span, key,
    input  ready
  );
  modport sink (
    input  valid, op, stage, slot, src_start, dst_start, span, key,
    output ready
  );
endinterface

`default_nettype wire

[rtl/crr_out_if.sv]
// Output channel: translated keys.
`timescale 1ns / 1ps
`default_nettype none

interface crr_out_if
  import crr_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] mapped;

  modport source (
    output valid, mapped,
    input  ready
  );
  modport sink (
    input  valid, mapped,
    output ready
  );
endinterface

`default_nettype wire

[rtl/chained_range_remap.sv]
// Top level: pipelined chain of interval-offset translation stages.
`timescale 1ns / 1ps
`default_nettype none

// Chained range remap. A translate transaction passes a 32-bit key through
// STAGES table stages; in each, the lowest-numbered entry with
// src <= key < src + span adds (dst - src) to the key, else the key passes
// unchanged. A load transaction writes one entry (span 0 empties it) and
// produces no output; loads with an out-of-range stage are dropped. Every
// stage owns a two-register slice (compare/select, then add), so the block
// takes one transaction per cycle when the output is not stalled. Loads
// travel down the same pipeline and update a table as they pass it, so
// every translate sees exactly the loads accepted before it. All entries
// are empty after reset.
module chained_range_remap
  import crr_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  crr_in_if.sink     in_i,
  crr_out_if.source  out_o
);

  // Table store, one bank per stage.
  logic [KeyW-1:0]     src_q  [STAGES][SEGMENTS];
  logic [KeyW-1:0]     off_q  [STAGES][SEGMENTS];
  logic [KeyW-1:0]     span_q [STAGES][SEGMENTS];
  logic [SEGMENTS-1:0] wr     [STAGES];

  // Pipeline: a = lookup slice, b = add slice.
  crr_pipe_t         a_q [STAGES];
  crr_pipe_t         a_d [STAGES];
  crr_pipe_t         b_q [STAGES];
  crr_pipe_t         b_d [STAGES];
  logic [STAGES-1:0] av_q;
  logic [STAGES-1:0] bv_q;
  logic [STAGES:0]   a_rdy;
  logic [STAGES-1:0] b_rdy;

  logic            out_valid_q;
  logic [KeyW-1:0] mapped_q;
  logic [KeyW-1:0] mapped_d;

  // Ready chain, collapsing bubbles.
  always_comb begin
    a_rdy[STAGES] = !out_valid_q || out_o.ready;
    for (int s = STAGES - 1; s >= 0; s--) begin
      b_rdy[s] = !bv_q[s] || a_rdy[s+1];
      a_rdy[s] = !av_q[s] || b_rdy[s];
    end
  end

  assign in_i.ready   = a_rdy[0];
  assign out_o.valid  = out_valid_q;
  assign out_o.mapped = mapped_q;

  // Lookup: parallel compare over the stage's entries, lowest match wins.
  always_comb begin
    logic [KeyW:0]       diff;
    logic [SEGMENTS-1:0] hit;
    logic [KeyW-1:0]     off_sel;
    for (int s = 0; s < STAGES; s++) begin
      for (int e = 0; e < SEGMENTS; e++) begin
        diff   = {1'b0, a_q[s].key} - {1'b0, src_q[s][e]};
        hit[e] = !diff[KeyW] && (diff[KeyW-1:0] < span_q[s][e]);
        wr[s][e] = av_q[s] && b_rdy[s] && (a_q[s].op == OP_LOAD)
                   && (int'(a_q[s].stage) == s) && (int'(a_q[s].slot) == e);
      end
      off_sel = '0;
      for (int e = SEGMENTS - 1; e >= 0; e--) begin
        if (hit[e]) begin
          off_sel = off_q[s][e];
        end
      end
      b_d[s] = a_q[s];
      if (a_q[s].op == OP_XLATE) begin
        b_d[s].off = off_sel;
      end
    end
  end

  // Input capture, and add slice feeding the next stage.
  always_comb begin
    a_d[0].op    = in_i.op;
    a_d[0].stage = in_i.stage;
    a_d[0].slot  = in_i.slot;
    a_d[0].key   = (in_i.op == OP_XLATE) ? in_i.key : in_i.src_start;
    a_d[0].off   = in_i.dst_start - in_i.src_start;
    a_d[0].span  = in_i.span;
    for (int s = 1; s < STAGES; s++) begin
      a_d[s] = b_q[s-1];
      if (b_q[s-1].op == OP_XLATE) begin
        a_d[s].key = b_q[s-1].key + b_q[s-1].off;
      end
    end
    mapped_d = b_q[STAGES-1].key + b_q[STAGES-1].off;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q        <= '0;
      bv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_rdy[0]) begin
        av_q[0] <= in_i.valid;
      end
      for (int s = 1; s < STAGES; s++) begin
        if (a_rdy[s]) begin
          av_q[s] <= bv_q[s-1];
        end
      end
      for (int s = 0; s < STAGES; s++) begin
        if (b_rdy[s]) begin
          bv_q[s] <= av_q[s];
        end
      end
      if (a_rdy[STAGES]) begin
        out_valid_q <= bv_q[STAGES-1] && (b_q[STAGES-1].op == OP_XLATE);
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < STAGES; s++) begin
      if (a_rdy[s]) begin
        a_q[s] <= a_d[s];
      end
      if (b_rdy[s]) begin
        b_q[s] <= b_d[s];
      end
    end
    if (a_rdy[STAGES]) begin
      mapped_q <= mapped_d;
    end
  end

  // Table store: spans reset so every slot starts empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STAGES; s++) begin
        for (int e = 0; e < SEGMENTS; e++) begin
          span_q[s][e] <= '0;
        end
      end
    end else begin
      for (int s = 0; s < STAGES; s++) begin
        for (int e = 0; e < SEGMENTS; e++) begin
          if (wr[s][e]) begin
            span_q[s][e] <= a_q[s].span;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < STAGES; s++) begin
      for (int e = 0; e < SEGMENTS; e++) begin
        if (wr[s][e]) begin
          src_q[s][e] <= a_q[s].key;
          off_q[s][e] <= a_q[s].off;
        end
      end
    end
  end

  // Input backpressure only when every slice up to the output is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled with room in the pipeline");

  // A new result only comes from a translate in the last slice.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(bv_q[STAGES-1] && (b_q[STAGES-1].op == OP_XLATE)))
    else $error("result without a translate transaction");

  // The span of stage 0, slot 0 changes only under a load in that stage's lookup slice.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(span_q[0][0]) |-> $past(av_q[0] && (a_q[0].op == OP_LOAD)))
    else $error("table entry changed without a load");

endmodule

`default_nettype wire
